>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/swl_pkg.sv
// ----------------------------------------------------------------------------
// swl_pkg
// Types and constants shared by the sleep list cells and the top level.
// ----------------------------------------------------------------------------
package swl_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int ID_BITS    = 8;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [7:0]         tid_t;
  typedef logic [31:0]        wake_t;

  // request codes
  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_WOKEN  = 2'd1;
  localparam logic [1:0] KIND_DECIDE = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  thread_id;
    logic [30:0] delay;
    logic        machine_idle;
    logic        other_pending;
  } in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] woken_id;
    logic       accepted;
    logic       yield_now;
    logic       timer_off;
    logic       last_result;
  } out_t;

  typedef struct packed {
    logic  valid;
    id_t   id;
    wake_t wake;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     wr_en;
    cnt_t     wr_idx;
  } cell_ctrl_t;

endpackage

>>> design/swl_cell.sv
// ----------------------------------------------------------------------------
// swl_cell
// One slot of the sleep list: holds an entry, loads new data on insert,
// takes its upper neighbor's entry on shift, or the recirculated head if it is the write slot.
// ----------------------------------------------------------------------------
module swl_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  swl_pkg::cell_ctrl_t ctrl,
  input  swl_pkg::cnt_t       my_idx,
  input  swl_pkg::entry_t     up,
  input  swl_pkg::entry_t     wr_data,
  output swl_pkg::entry_t     q
);

  swl_pkg::entry_t ent_r;
  swl_pkg::entry_t ent_nxt;
  logic            hit;

  assign hit = (ctrl.wr_idx == my_idx);

  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.op)
      swl_pkg::CELL_HOLD: begin
        ent_nxt = ent_r;
      end
      swl_pkg::CELL_INSERT: begin
        if (hit) begin
          ent_nxt = wr_data;
        end
      end
      swl_pkg::CELL_SHIFT: begin
        // a kept head recirculates into the current tail slot
        if (ctrl.wr_en && hit) begin
          ent_nxt = wr_data;
        end else begin
          ent_nxt = up;
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  // only the valid bit is reset; id and wake time are don't-care until loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign q = ent_r;

endmodule

>>> design/sleep_wakeup_list.sv
// ----------------------------------------------------------------------------
// sleep_wakeup_list
// Bounded sleep list of thread ids with absolute 32-bit wake times.
// ----------------------------------------------------------------------------
// A sleep request returns one acknowledge. A timer tick is first accepted,
// then the chain of cells shifts each stored entry in turn past the head cell,
// where its wake time is compared against the time counter, then the
// decision is made. Expired ids leave as woken transfers, the others
// recirculate to the tail, so order is kept. The tick ends with one decision
// transfer. A new request is taken only between ticks; a stalled result side
// holds the scan while an expired head waits to leave, and holds the decision.
module sleep_wakeup_list (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  swl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output swl_pkg::out_t out_data
);

`include "assert_macros.svh"

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t              state_r;
  state_t              state_nxt;
  swl_pkg::wake_t      time_r;
  swl_pkg::wake_t      time_nxt;
  swl_pkg::cnt_t       cnt_r;
  swl_pkg::cnt_t       cnt_nxt;
  swl_pkg::cnt_t       steps_r;
  swl_pkg::cnt_t       steps_nxt;
  logic                woken_r;
  logic                woken_nxt;
  logic                idle_r;
  logic                idle_nxt;
  logic                pend_r;
  logic                pend_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  swl_pkg::out_t       out_r;
  swl_pkg::out_t       out_nxt;

  swl_pkg::cell_ctrl_t ctrl;
  swl_pkg::entry_t     wr_data;
  swl_pkg::entry_t     q   [swl_pkg::LIST_DEPTH];
  swl_pkg::entry_t     up  [swl_pkg::LIST_DEPTH];

  logic                slot_free;
  logic                in_fire;
  logic                full;
  logic                expired;
  logic                scan_go;
  swl_pkg::wake_t      diff;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign full      = (cnt_r == swl_pkg::cnt_t'(swl_pkg::LIST_DEPTH));
  assign diff      = time_r - q[0].wake;
  assign expired   = !diff[31];
  assign scan_go   = (state_r == S_SCAN) && (steps_r != '0) && (!expired || slot_free);

  // cell control
  always_comb begin
    ctrl.op     = swl_pkg::CELL_HOLD;
    ctrl.wr_en  = 1'b0;
    ctrl.wr_idx = cnt_r;
    wr_data     = q[0];
    if (in_fire && (in_data.req_type == swl_pkg::REQ_SLEEP) && !full) begin
      ctrl.op       = swl_pkg::CELL_INSERT;
      ctrl.wr_en    = 1'b1;
      ctrl.wr_idx   = cnt_r;
      wr_data.valid = 1'b1;
      wr_data.id    = swl_pkg::id_t'(in_data.thread_id);
      wr_data.wake  = time_r + swl_pkg::wake_t'(in_data.delay);
    end else if (scan_go) begin
      ctrl.op     = swl_pkg::CELL_SHIFT;
      ctrl.wr_en  = !expired;
      ctrl.wr_idx = swl_pkg::cnt_t'(cnt_r - 1'b1);
      wr_data     = q[0];
    end
  end

  for (genvar i = 0; i < swl_pkg::LIST_DEPTH; i++) begin : g_cell
    if (i == swl_pkg::LIST_DEPTH - 1) begin : g_last
      assign up[i] = '0;
    end else begin : g_mid
      assign up[i] = q[i+1];
    end
    swl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .my_idx  (swl_pkg::cnt_t'(i)),
      .up      (up[i]),
      .wr_data (wr_data),
      .q       (q[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    time_nxt      = time_r;
    cnt_nxt       = cnt_r;
    steps_nxt     = steps_r;
    woken_nxt     = woken_r;
    idle_nxt      = idle_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.req_type == swl_pkg::REQ_SLEEP) begin
            out_valid_nxt       = 1'b1;
            out_nxt             = '0;
            out_nxt.result_kind = swl_pkg::KIND_ACK;
            out_nxt.accepted    = !full;
            out_nxt.last_result = 1'b1;
            if (!full) begin
              cnt_nxt = swl_pkg::cnt_t'(cnt_r + 1'b1);
            end
          end else begin
            time_nxt  = time_r + 32'd1;
            steps_nxt = cnt_r;
            woken_nxt = 1'b0;
            idle_nxt  = in_data.machine_idle;
            pend_nxt  = in_data.other_pending;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (steps_r != '0) begin
          if (scan_go) begin
            steps_nxt = swl_pkg::cnt_t'(steps_r - 1'b1);
            if (expired) begin
              cnt_nxt             = swl_pkg::cnt_t'(cnt_r - 1'b1);
              woken_nxt           = 1'b1;
              out_valid_nxt       = 1'b1;
              out_nxt             = '0;
              out_nxt.result_kind = swl_pkg::KIND_WOKEN;
              out_nxt.woken_id    = swl_pkg::tid_t'(q[0].id);
            end
          end
        end else if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.result_kind = swl_pkg::KIND_DECIDE;
          out_nxt.last_result = 1'b1;
          if (idle_r && !woken_r && (cnt_r == '0)) begin
            out_nxt.yield_now = 1'b0;
            out_nxt.timer_off = !pend_r;
          end else begin
            out_nxt.yield_now = 1'b1;
            out_nxt.timer_off = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_r      <= '0;
      cnt_r       <= '0;
      steps_r     <= '0;
      woken_r     <= 1'b0;
      idle_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      cnt_r       <= cnt_nxt;
      steps_r     <= steps_nxt;
      woken_r     <= woken_nxt;
      idle_r      <= idle_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid_r, "result valid after reset")
  `ASSERT_CLK(a_cnt_bound, cnt_r <= swl_pkg::cnt_t'(swl_pkg::LIST_DEPTH), "count over depth")
  `ASSERT_CLK(a_steps_bound, state_r == S_SCAN |-> steps_r <= cnt_r, "scan steps exceed count")
  `ASSERT_CLK(a_head_prefix, state_r == S_IDLE |-> q[0].valid == (cnt_r != '0), "head valid mismatch")
  `ASSERT_CLK(a_wake_drop, scan_go && expired |=> cnt_r == $past(cnt_r) - 1'b1, "woken entry kept")

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sleep list: a directed table, then random
// sleep and tick traffic under several idle/stall mixes. Every result
// transfer is checked in order against a predictor of the list.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    swl_pkg::id_t   id;
    swl_pkg::wake_t wake;
  } sleeper_t;

  typedef struct {
    swl_pkg::in_t  stim;
    logic          typed;
    swl_pkg::out_t want;
  } plan_row_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  swl_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  swl_pkg::out_t out_data;

  sleep_wakeup_list u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // predictor state
  logic [31:0]   model_time = '0;
  sleeper_t      sleepers[$];
  swl_pkg::out_t predicted_results[$];

  plan_row_t plan[$];
  int        mismatches     = 0;
  int        send_gap_pct   = 0;
  int        recv_stall_pct = 0;
  int        recv_hold_len  = 0;
  int        gap_pcts[4]    = '{0, 72, 0, 19};
  int        stall_pcts[4]  = '{0, 0, 72, 19};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL sleep_wakeup_list");
    $finish;
  end

  // Works out the transfers one accepted request causes and updates the list.
  function automatic void predict_sleep_list(input swl_pkg::in_t item);
    sleeper_t      kept[$];
    sleeper_t      s;
    swl_pkg::out_t r;
    logic [31:0]   diff;
    logic          woke;
    woke = 1'b0;
    if (item.req_type == swl_pkg::REQ_SLEEP) begin
      r = '0;
      r.result_kind = swl_pkg::KIND_ACK;
      r.last_result = 1'b1;
      if (sleepers.size() < swl_pkg::LIST_DEPTH) begin
        s.id   = item.thread_id[swl_pkg::ID_BITS-1:0];
        s.wake = model_time + {1'b0, item.delay};
        sleepers = {sleepers, s};
        r.accepted = 1'b1;
      end
      predicted_results = {predicted_results, r};
    end else begin
      model_time = model_time + 32'd1;
      foreach (sleepers[i]) begin
        diff = model_time - sleepers[i].wake;
        if (!diff[31]) begin
          woke = 1'b1;
          r = '0;
          r.result_kind = swl_pkg::KIND_WOKEN;
          r.woken_id    = sleepers[i].id;
          predicted_results = {predicted_results, r};
        end else begin
          kept = {kept, sleepers[i]};
        end
      end
      sleepers = kept;
      r = '0;
      r.result_kind = swl_pkg::KIND_DECIDE;
      r.last_result = 1'b1;
      if (item.machine_idle && !woke && sleepers.size() == 0)
        r.timer_off = !item.other_pending;
      else
        r.yield_now = 1'b1;
      predicted_results = {predicted_results, r};
    end
  endfunction

  task automatic flag_mismatch(input string what, input swl_pkg::out_t got,
                               input swl_pkg::out_t want);
    $display("%0t mismatch on %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input swl_pkg::out_t got);
    swl_pkg::out_t want;
    if (predicted_results.size() == 0) begin
      flag_mismatch("unexpected transfer", got, '0);
    end else begin
      want = predicted_results.pop_front();
      if (got.result_kind !== want.result_kind) flag_mismatch("result_kind", got, want);
      if (got.woken_id !== want.woken_id) flag_mismatch("woken_id", got, want);
      if (got.accepted !== want.accepted) flag_mismatch("accepted", got, want);
      if (got.yield_now !== want.yield_now) flag_mismatch("yield_now", got, want);
      if (got.timer_off !== want.timer_off) flag_mismatch("timer_off", got, want);
      if (got.last_result !== want.last_result) flag_mismatch("last_result", got, want);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_len != 0) begin
        out_ready = 1'b0;
        repeat (recv_hold_len) @(negedge clk);
        recv_hold_len = 0;
      end
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Entered and left at a falling edge; valid stays up between back-to-back items.
  task automatic send_item(input swl_pkg::in_t item, input logic typed,
                           input swl_pkg::out_t want);
    int held;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    held = predicted_results.size();
    predict_sleep_list(item);
    if (typed) begin
      while (predicted_results.size() > held) void'(predicted_results.pop_back());
      predicted_results = {predicted_results, want};
    end
    @(negedge clk);
  endtask

  function automatic swl_pkg::in_t stim_of(input logic req, input int tid, input int dly,
                                           input logic idle, input logic pend);
    swl_pkg::in_t item;
    item.req_type      = req;
    item.thread_id     = tid[7:0];
    item.delay         = dly[30:0];
    item.machine_idle  = idle;
    item.other_pending = pend;
    return item;
  endfunction

  function automatic swl_pkg::out_t ack_of(input logic acc);
    swl_pkg::out_t r;
    r = '0;
    r.result_kind = swl_pkg::KIND_ACK;
    r.accepted    = acc;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic swl_pkg::out_t decision_of(input logic yld, input logic toff);
    swl_pkg::out_t r;
    r = '0;
    r.result_kind = swl_pkg::KIND_DECIDE;
    r.yield_now   = yld;
    r.timer_off   = toff;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input swl_pkg::in_t stim, input logic typed,
                                  input swl_pkg::out_t want);
    plan_row_t row;
    row.stim  = stim;
    row.typed = typed;
    row.want  = want;
    plan = {plan, row};
  endfunction

  function automatic void build_plan();
    // empty list: idle with and without pending interrupts, then busy;
    // id and delay must be ignored on a tick
    add_row(stim_of(swl_pkg::REQ_TICK, 8'hFF, 32'h7FFF_FFFF, 1'b1, 1'b0), 1'b1,
            decision_of(1'b0, 1'b1));
    add_row(stim_of(swl_pkg::REQ_TICK, 0, 0, 1'b1, 1'b1), 1'b1, decision_of(1'b0, 1'b0));
    add_row(stim_of(swl_pkg::REQ_TICK, 0, 0, 1'b0, 1'b0), 1'b1, decision_of(1'b1, 1'b0));
    // zero delay wakes on the very next tick; idle/pending ignored on a sleep
    add_row(stim_of(swl_pkg::REQ_SLEEP, 8'hFF, 0, 1'b1, 1'b1), 1'b1, ack_of(1'b1));
    add_row(stim_of(swl_pkg::REQ_TICK, 0, 0, 1'b1, 1'b0), 1'b0, '0);
    add_row(stim_of(swl_pkg::REQ_TICK, 0, 0, 1'b1, 1'b0), 1'b1, decision_of(1'b0, 1'b1));
    // fill every slot, then one more is refused
    for (int i = 0; i < swl_pkg::LIST_DEPTH; i++)
      add_row(stim_of(swl_pkg::REQ_SLEEP, i * 17, i % 3, 1'b0, 1'b0), 1'b1, ack_of(1'b1));
    add_row(stim_of(swl_pkg::REQ_SLEEP, 8'h5A, 32'h7FFF_FFFF, 1'b1, 1'b1), 1'b1,
            ack_of(1'b0));
    // drain over three ticks: delays 0 and 1 wake on the first, in list order, delay 2 on the second
    for (int i = 0; i < 3; i++)
      add_row(stim_of(swl_pkg::REQ_TICK, 8'hA5, i * 12345, i != 0, i == 0), 1'b0, '0);
  endfunction

  // Random fields everywhere; a sleep into a non-full list gets a short delay
  // so entries keep waking. A full list sees wide delays, refused anyway.
  function automatic swl_pkg::in_t random_item(input logic filling);
    swl_pkg::in_t item;
    logic [63:0]  noise;
    noise = {$urandom, $urandom};
    item  = noise[$bits(swl_pkg::in_t)-1:0];
    item.req_type = ($urandom_range(99) < (filling ? 85 : 50)) ?
                    swl_pkg::REQ_SLEEP : swl_pkg::REQ_TICK;
    if (item.req_type == swl_pkg::REQ_SLEEP && sleepers.size() < swl_pkg::LIST_DEPTH)
      item.delay = ($urandom_range(7) == 0) ? 31'($urandom_range(60)) : 31'($urandom_range(5));
    return item;
  endfunction

  initial begin
    logic filling;
    filling  = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    build_plan();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) send_item(plan[i].stim, plan[i].typed, plan[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      send_gap_pct   = gap_pcts[phase];
      recv_stall_pct = stall_pcts[phase];
      // long hold-off on the result side while requests keep coming
      if (phase == 0) recv_hold_len = 300;
      for (int n = 0; n < 110; n++) begin
        if (n % 25 == 0) filling = ($urandom_range(2) == 0);
        send_item(random_item(filling), 1'b0, '0);
      end
    end
    in_valid = 1'b0;

    while (predicted_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("PASS sleep_wakeup_list");
    else
      $display("FAIL sleep_wakeup_list");
    $finish;
  end

endmodule
